FILE: hw/rtl/atmt_pkg.sv
// ----------------------------------------------------------------------------
// atmt_pkg
// Shared types, constants and helpers of the adapter tail match trimmer.
// ----------------------------------------------------------------------------
package atmt_pkg;

  localparam int unsigned AdapterChars = 32;
  localparam int unsigned AdapterWords = 4;
  localparam int unsigned CfgIdxW      = 3;
  localparam int unsigned CfgDataW     = 64;
  localparam int unsigned LenW         = 16;
  localparam int unsigned FracW        = 17;

  localparam logic [CfgIdxW-1:0] RegAdapterWord0 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegAdapterWord1 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegAdapterWord2 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegAdapterWord3 = 3'd3;
  localparam logic [CfgIdxW-1:0] RegAdapterLen   = 3'd4;
  localparam logic [CfgIdxW-1:0] RegMinBases     = 3'd5;
  localparam logic [CfgIdxW-1:0] RegMatchFrac    = 3'd6;

  localparam logic [7:0]       DefaultMinBases = 8'd5;
  localparam logic [FracW-1:0] DefaultFracQ16  = 17'd58982;
  localparam logic [FracW-1:0] Q16One          = 17'd65536;
  localparam logic [7:0]       CharWild        = 8'h4E;

  typedef struct packed {
    logic shift;
    logic use_hit;
  } cell_ctrl_t;

  function automatic logic [7:0] fold_char(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'd32;
    end
    return r;
  endfunction

endpackage

FILE: hw/rtl/atmt_cell.sv
// ----------------------------------------------------------------------------
// atmt_cell
// One alignment cell: compares the incoming base with its adapter character
// and passes the running match count on to the next cell.
// ----------------------------------------------------------------------------
module atmt_cell #(
  parameter int unsigned CNT_W = 6
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  atmt_pkg::cell_ctrl_t  ctrl_i,
  input  logic [7:0]            base_i,
  input  logic [7:0]            adapter_char_i,
  input  logic [CNT_W-1:0]      prev_cnt_i,
  output logic [CNT_W-1:0]      cnt_o
);

  logic [7:0]       achar;
  logic             hit;
  logic [CNT_W-1:0] cnt_d, cnt_q;

  assign achar = atmt_pkg::fold_char(adapter_char_i);
  assign hit   = ctrl_i.use_hit &&
                 (base_i == atmt_pkg::CharWild || achar == atmt_pkg::CharWild ||
                  base_i == achar);
  assign cnt_d = prev_cnt_i + CNT_W'(hit);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (ctrl_i.shift) begin
      cnt_q <= cnt_d;
    end
  end

  assign cnt_o = cnt_q;

endmodule

FILE: hw/rtl/adapter_tail_match_trimmer_top.sv
// ----------------------------------------------------------------------------
// adapter_tail_match_trimmer_top
// Anchored 3' adapter trimmer built as a chain of alignment cells with a
// scan sequencer that picks the leftmost qualifying alignment at read end.
// ----------------------------------------------------------------------------
//   Channel   Direction  Handshake              Payload
//   in        input      in_valid_i/in_stall_o  base_i, last_i
//   out       output     out_valid_o/out_stall_i trim_length_o, trimmed_o, too_long_o
//   cfg       input      cfg_we_i               cfg_index_i, cfg_data_i
//
// A base that does not end the read only shifts the cells and counts the read length.
// A base that ends the read starts a scan: the cells shift their counts past
// the tail cell once, one alignment per cycle, then the result waits in the
// hold state until the output is free and is loaded into the output register.
// Reset clears the cells, the read position and the output valid flag.
// A result waiting in the output register does not block new bases; only the scan and hold states do.
// ----------------------------------------------------------------------------
module adapter_tail_match_trimmer_top #(
  parameter int unsigned MAX_ADAPTER  = 32,
  parameter int unsigned MAX_READ_LEN = 65535
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [atmt_pkg::CfgIdxW-1:0]        cfg_index_i,
  input  logic [atmt_pkg::CfgDataW-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [7:0]                          base_i,
  input  logic                                last_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [atmt_pkg::LenW-1:0]           trim_length_o,
  output logic                                trimmed_o,
  output logic                                too_long_o
);

  localparam int unsigned CELLS = (MAX_ADAPTER < atmt_pkg::AdapterChars) ?
                                  MAX_ADAPTER : atmt_pkg::AdapterChars;
  localparam int unsigned CW    = $clog2(CELLS + 1);
  localparam int unsigned PW    = CW + 16;
  localparam int unsigned LenW  = atmt_pkg::LenW;
  localparam int unsigned FracW = atmt_pkg::FracW;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [atmt_pkg::CfgDataW-1:0] adapter_word_q [atmt_pkg::AdapterWords];
  logic [5:0]                    adapter_len_q;
  logic [7:0]                    min_bases_q;
  logic [FracW-1:0]              frac_q;

  logic [7:0]       min_bases_eff;
  logic [FracW-1:0] frac_eff;

  logic [1:0]       state_d, state_q;
  logic [LenW-1:0]  len_q;
  logic             ovf_q;
  logic [CW-1:0]    eff_q;
  logic [PW-1:0]    prod_q;
  logic             found_q;
  logic [CW-1:0]    found_eff_q;

  logic             out_valid_q;
  logic [LenW-1:0]  trim_length_q;
  logic             trimmed_q;
  logic             too_long_q;

  logic                 in_xfer;
  logic                 out_free;
  logic [7:0]           base_f;
  atmt_pkg::cell_ctrl_t cell_ctrl;
  logic [CW-1:0]        cnt [CELLS];
  logic [CELLS-1:0]     cnt_nz;
  logic [CW-1:0]        tail_cnt;
  logic                 pass;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < atmt_pkg::AdapterWords; i++) begin
        adapter_word_q[i] <= '0;
      end
      adapter_len_q <= '0;
      min_bases_q   <= atmt_pkg::DefaultMinBases;
      frac_q        <= atmt_pkg::DefaultFracQ16;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        atmt_pkg::RegAdapterWord0: adapter_word_q[0] <= cfg_data_i;
        atmt_pkg::RegAdapterWord1: adapter_word_q[1] <= cfg_data_i;
        atmt_pkg::RegAdapterWord2: adapter_word_q[2] <= cfg_data_i;
        atmt_pkg::RegAdapterWord3: adapter_word_q[3] <= cfg_data_i;
        atmt_pkg::RegAdapterLen:   adapter_len_q     <= cfg_data_i[5:0];
        atmt_pkg::RegMinBases:     min_bases_q       <= cfg_data_i[7:0];
        atmt_pkg::RegMatchFrac:    frac_q            <= cfg_data_i[FracW-1:0];
        default: ;
      endcase
    end
  end

  assign min_bases_eff = (min_bases_q == '0) ? atmt_pkg::DefaultMinBases : min_bases_q;
  assign frac_eff      = (frac_q == '0 || frac_q > atmt_pkg::Q16One) ?
                         atmt_pkg::DefaultFracQ16 : frac_q;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign base_f     = atmt_pkg::fold_char(base_i);

  assign cell_ctrl.shift   = in_xfer || (state_q == ST_SCAN);
  assign cell_ctrl.use_hit = in_xfer;

  for (genvar a = 0; a < CELLS; a++) begin : g_cell
    logic [CW-1:0] prev;
    if (a == 0) begin : g_head
      assign prev = '0;
    end else begin : g_link
      assign prev = cnt[a-1];
    end
    atmt_cell #(
      .CNT_W(CW)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (cell_ctrl),
      .base_i        (base_f),
      .adapter_char_i(adapter_word_q[a/8][8*(a%8) +: 8]),
      .prev_cnt_i    (prev),
      .cnt_o         (cnt[a])
    );
    assign cnt_nz[a] = (cnt[a] != '0);
  end

  assign tail_cnt = cnt[CELLS-1];
  assign pass = (8'(eff_q) >= min_bases_eff) &&
                (6'(eff_q) <= adapter_len_q) &&
                (LenW'(eff_q) <= len_q) &&
                ({tail_cnt, 16'b0} >= prod_q);

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_xfer && last_i) state_d = ST_SCAN;
      ST_SCAN: if (eff_q == CW'(1)) state_d = ST_HOLD;
      ST_HOLD: if (out_free) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      len_q   <= '0;
      ovf_q   <= 1'b0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_xfer) begin
        if (len_q < LenW'(MAX_READ_LEN)) begin
          len_q <= len_q + LenW'(1);
        end else begin
          ovf_q <= 1'b1;
        end
        if (last_i) begin
          found_q <= 1'b0;
        end
      end else if (state_q == ST_SCAN) begin
        if (pass && !found_q) begin
          found_q <= 1'b1;
        end
      end else if (state_q == ST_HOLD && out_free) begin
        len_q <= '0;
        ovf_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer && last_i) begin
      eff_q  <= CW'(CELLS);
      prod_q <= PW'(CELLS) * PW'(frac_eff);
    end else if (state_q == ST_SCAN) begin
      eff_q  <= eff_q - CW'(1);
      prod_q <= prod_q - PW'(frac_eff);
      if (pass && !found_q) begin
        found_eff_q <= eff_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (state_q == ST_HOLD && out_free) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_HOLD && out_free) begin
      if (ovf_q) begin
        trim_length_q <= LenW'(MAX_READ_LEN);
        trimmed_q     <= 1'b0;
        too_long_q    <= 1'b1;
      end else if (found_q) begin
        trim_length_q <= len_q - LenW'(found_eff_q);
        trimmed_q     <= 1'b1;
        too_long_q    <= 1'b0;
      end else begin
        trim_length_q <= len_q;
        trimmed_q     <= 1'b0;
        too_long_q    <= 1'b0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign trim_length_o = trim_length_q;
  assign trimmed_o     = trimmed_q;
  assign too_long_o    = too_long_q;

  a_last_starts_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && last_i) |=> (state_q == ST_SCAN))
    else $error("read end did not start the scan");

  a_cells_clear_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HOLD) |-> (cnt_nz == '0))
    else $error("cells not cleared after scan");

  a_found_meets_min: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HOLD && found_q) |-> (8'(found_eff_q) >= min_bases_eff))
    else $error("accepted alignment shorter than minimum overlap");

  a_flags_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(trimmed_q && too_long_q))
    else $error("trimmed and too_long both set");

endmodule
